[rtl/cpst_pkg.sv]
// Shared types, port widths and defaults for the coordinate pair set table.
`default_nettype none

package cpst_pkg;

    // Default sizing of the table.
    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_COORD_BITS = 16;

    // Fixed widths of the item and result fields.
    localparam int KIND_W    = 2;
    localparam int COORD_W   = 16;
    localparam int POS_OUT_W = 8;
    localparam int CNT_OUT_W = 9;

    // Operation codes; the unused code behaves as a lookup.
    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2
    } t_kind;

    // Single-bit flags of one finished item.
    typedef struct packed {
        logic hit;
        logic status;
    } t_res_flags;

endpackage

`default_nettype wire

[rtl/cpst_store.sv]
// Pair storage: one write port and one registered read port.
`default_nettype none

module cpst_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/cpst_seq.sv]
// Sequencer: linear search with one shared comparator, append and compaction.
`default_nettype none

module cpst_seq #(
    parameter int CAPACITY   = cpst_pkg::DEF_CAPACITY,
    parameter int COORD_BITS = cpst_pkg::DEF_COORD_BITS,
    parameter int IDX_W      = 8,
    parameter int CNT_W      = 9
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Incoming item
    input  wire logic                          i_in_valid,
    output logic                               o_busy,
    input  wire logic [cpst_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [cpst_pkg::COORD_W-1:0]  i_row,
    input  wire logic [cpst_pkg::COORD_W-1:0]  i_col,
    // Finished item
    output logic                               o_done,
    input  wire logic                          i_out_free,
    output cpst_pkg::t_res_flags               o_flags,
    output logic      [IDX_W-1:0]              o_pos,
    output logic      [CNT_W-1:0]              o_count,
    // Storage port
    output logic                               o_we,
    output logic      [IDX_W-1:0]              o_waddr,
    output logic      [2*COORD_BITS-1:0]       o_wdata,
    output logic      [IDX_W-1:0]              o_raddr,
    input  wire logic [2*COORD_BITS-1:0]       i_rdata
);

    import cpst_pkg::*;

    localparam int KEY_W = 2 * COORD_BITS;
    localparam int CMP_W = CNT_W + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_CMP  = 6'b000100,
        S_ACT  = 6'b001000,
        S_SHRD = 6'b010000,
        S_SHWR = 6'b100000
    } t_state;

    // S_DONE is folded into a flag so that the state register stays small.
    t_state            r_state, n_state;
    logic              r_done, n_done;
    t_kind             r_kind, n_kind;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_found, n_found;
    logic              r_status, n_status;

    logic [COORD_BITS+COORD_W-1:0] w_row_ext, w_col_ext;
    logic [CMP_W-1:0]  w_idx_p1, w_idx_p2, w_cnt_x, w_cap_x;

    // Only the low COORD_BITS bits of each coordinate take part.
    assign w_row_ext = {{COORD_BITS{1'b0}}, i_row};
    assign w_col_ext = {{COORD_BITS{1'b0}}, i_col};

    assign w_idx_p1 = CMP_W'(r_idx) + CMP_W'(1);
    assign w_idx_p2 = CMP_W'(r_idx) + CMP_W'(2);
    assign w_cnt_x  = CMP_W'(r_count);
    assign w_cap_x  = CMP_W'(CAPACITY);

    // Next-state and storage control.
    always_comb begin
        n_state  = r_state;
        n_done   = r_done;
        n_kind   = r_kind;
        n_key    = r_key;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_count  = r_count;
        n_found  = r_found;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = r_idx;
        o_wdata  = r_key;
        o_raddr  = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (r_done) begin
                    // Result waits until the output register can take it.
                    if (i_out_free) begin
                        n_done = 1'b0;
                    end
                end else if (i_in_valid) begin
                    n_kind   = t_kind'(i_kind);
                    n_key    = {w_row_ext[COORD_BITS-1:0], w_col_ext[COORD_BITS-1:0]};
                    n_idx    = '0;
                    n_pos    = '0;
                    n_found  = 1'b0;
                    n_status = 1'b0;
                    n_state  = (r_count == '0) ? S_ACT : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                // One entry compared per visit, from index zero upward.
                if (i_rdata == r_key) begin
                    n_found = 1'b1;
                    n_pos   = r_idx;
                    n_state = S_ACT;
                end else if (w_idx_p1 >= w_cnt_x) begin
                    n_state = S_ACT;
                end else begin
                    n_idx   = w_idx_p1[IDX_W-1:0];
                    n_state = S_RD;
                end
            end
            S_ACT: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (r_kind == KIND_INSERT && !r_found) begin
                    if (w_cnt_x >= w_cap_x) begin
                        n_status = 1'b1;
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = r_count[IDX_W-1:0];
                        n_pos   = r_count[IDX_W-1:0];
                        n_count = r_count + CNT_W'(1);
                    end
                end else if (r_kind == KIND_REMOVE && r_found) begin
                    if (w_idx_p1 < w_cnt_x) begin
                        n_state = S_SHRD;
                        n_done  = 1'b0;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            S_SHRD: begin
                o_raddr = w_idx_p1[IDX_W-1:0];
                n_state = S_SHWR;
            end
            S_SHWR: begin
                // Move the later entry down one place.
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = i_rdata;
                n_idx   = w_idx_p1[IDX_W-1:0];
                if (w_idx_p2 >= w_cnt_x) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = S_SHRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign o_busy         = (r_state != S_IDLE) || r_done;
    assign o_done         = r_done;
    assign o_flags.hit    = r_found;
    assign o_flags.status = r_status;
    assign o_pos          = r_pos;
    assign o_count        = r_count;

endmodule

`default_nettype wire

[rtl/coordinate_pair_set_table.sv]
// A search reads one stored pair at a time through the single read port, states S_RD then S_CMP,
// until a match or the last stored pair; S_ACT then finishes the item, and a removal moves each
// later entry down one place through S_SHRD and S_SHWR. The slowest items are a full search and a
// removal on a full table; the next item is taken once the result has been handed on.
// One item is in work at a time; the result register frees the sequencer once loaded.
// Reset (synchronous, active low) empties the table at once; the storage needs no clearing.
`default_nettype none

module coordinate_pair_set_table #(
    parameter int CAPACITY   = cpst_pkg::DEF_CAPACITY,
    parameter int COORD_BITS = cpst_pkg::DEF_COORD_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [cpst_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [cpst_pkg::COORD_W-1:0]    i_row,
    input  wire logic [cpst_pkg::COORD_W-1:0]    i_col,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_hit,
    output logic      [cpst_pkg::POS_OUT_W-1:0]  o_position,
    output logic      [cpst_pkg::CNT_OUT_W-1:0]  o_count,
    output logic                                 o_status
);

    import cpst_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KEY_W = 2 * COORD_BITS;

    logic              w_busy, w_done, w_out_free;
    t_res_flags        w_flags;
    logic [IDX_W-1:0]  w_pos;
    logic [CNT_W-1:0]  w_count;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr, w_raddr;
    logic [KEY_W-1:0]  w_wdata, w_rdata;
    logic [IDX_W+POS_OUT_W-1:0] w_pos_ext;
    logic [CNT_W+CNT_OUT_W-1:0] w_cnt_ext;

    logic                  r_out_valid;
    logic                  r_hit, r_status;
    logic [POS_OUT_W-1:0]  r_position;
    logic [CNT_OUT_W-1:0]  r_count;

    cpst_seq #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_busy     (w_busy),
        .i_kind     (i_kind),
        .i_row      (i_row),
        .i_col      (i_col),
        .o_done     (w_done),
        .i_out_free (w_out_free),
        .o_flags    (w_flags),
        .o_pos      (w_pos),
        .o_count    (w_count),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata)
    );

    cpst_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W),
        .DATA_W (KEY_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // The result register can take an item when empty or being emptied.
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Result fields are reported modulo their port widths.
    assign w_pos_ext = {{POS_OUT_W{1'b0}}, w_pos};
    assign w_cnt_ext = {{CNT_OUT_W{1'b0}}, w_count};

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_done;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_out_free && w_done) begin
            r_hit      <= w_flags.hit;
            r_status   <= w_flags.status;
            r_position <= w_pos_ext[POS_OUT_W-1:0];
            r_count    <= w_cnt_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_position  = r_position;
    assign o_count     = r_count;
    assign o_status    = r_status;

endmodule

`default_nettype wire

[verif/tb.sv]
// Testbench for the coordinate pair set table: directed and random items checked against a shadow table.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpst_pkg::*;

    localparam int TABLE_DEPTH = DEF_CAPACITY;
    // Allows several times the longest item, a full search or a removal on a full table.
    localparam int IDLE_LIMIT  = 8000;
    localparam int TAIL_CYCLES = 40;
    // The unused operation code, which the block treats as a lookup.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // One result as the block reports it.
    typedef struct packed {
        logic                 hit;
        logic [POS_OUT_W-1:0] position;
        logic [CNT_OUT_W-1:0] count;
        logic                 status;
    } t_answer;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [KIND_W-1:0]    i_kind      = KIND_LOOKUP;
    logic [COORD_W-1:0]   i_row       = '0;
    logic [COORD_W-1:0]   i_col       = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_hit;
    logic [POS_OUT_W-1:0] o_position;
    logic [CNT_OUT_W-1:0] o_count;
    logic                 o_status;

    // Shadow copy of the stored pairs, kept in table order.
    logic [COORD_W-1:0] shadow_rows [TABLE_DEPTH];
    logic [COORD_W-1:0] shadow_cols [TABLE_DEPTH];
    int                 shadow_count = 0;
    t_answer            awaited_results [$];

    int mismatches      = 0;
    int results_seen    = 0;
    int items_sent      = 0;
    int hits_seen       = 0;
    int shifted_removes = 0;
    int refused_inserts = 0;
    int peak_count      = 0;
    int quiet_cycles    = 0;
    bit steady          = 1'b0;

    coordinate_pair_set_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_row       (i_row),
        .i_col       (i_col),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hit       (o_hit),
        .o_position  (o_position),
        .o_count     (o_count),
        .o_status    (o_status)
    );

    always #6 i_clk = ~i_clk;

    // Index of a stored pair in the shadow table, or -1 when it is absent.
    function automatic int find_pair(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_rows[i] == row && shadow_cols[i] == col) return i;
        end
        return -1;
    endfunction

    // Applies one operation to the shadow table and returns the result it should give.
    function automatic t_answer predict_table_op(input logic [KIND_W-1:0] kind,
                                                 input logic [COORD_W-1:0] row,
                                                 input logic [COORD_W-1:0] col);
        t_answer ans;
        int      at;
        ans = '0;
        at  = find_pair(row, col);
        if (at >= 0) begin
            ans.hit      = 1'b1;
            ans.position = at[POS_OUT_W-1:0];
            hits_seen++;
        end
        if (kind == KIND_INSERT && at < 0) begin
            if (shadow_count >= TABLE_DEPTH) begin
                ans.status = 1'b1;
                refused_inserts++;
            end else begin
                shadow_rows[shadow_count] = row;
                shadow_cols[shadow_count] = col;
                ans.position = shadow_count[POS_OUT_W-1:0];
                shadow_count++;
            end
        end else if (kind == KIND_REMOVE && at >= 0) begin
            // Later entries move down one place and keep their order.
            if (at + 1 < shadow_count) shifted_removes++;
            for (int i = at; i + 1 < shadow_count; i++) begin
                shadow_rows[i] = shadow_rows[i + 1];
                shadow_cols[i] = shadow_cols[i + 1];
            end
            shadow_count--;
        end
        if (shadow_count > peak_count) peak_count = shadow_count;
        ans.count = shadow_count[CNT_OUT_W-1:0];
        return ans;
    endfunction

    // A small set of coordinates, so that random pairs often meet stored ones.
    function automatic logic [COORD_W-1:0] pool_coord(input int idx);
        case (idx)
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001;
            3:       return 16'h8000;
            4:       return 16'hAAAA;
            5:       return 16'h5555;
            6:       return 16'h7FFF;
            default: return 16'h00FF;
        endcase
    endfunction

    // Draws a pair that the table does not hold.
    task automatic draw_fresh_pair(output logic [COORD_W-1:0] row, output logic [COORD_W-1:0] col);
        do begin
            row = COORD_W'($urandom_range(16'hFFFF));
            col = COORD_W'($urandom_range(16'hFFFF));
        end while (find_pair(row, col) >= 0);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100) $display("MISMATCH at result %0d: %s", results_seen, msg);
    endtask

    // Presents one item after an optional random gap and returns once it is accepted.
    // Valid stays high on return so that a following item can replace it without a gap.
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] row,
                           input logic [COORD_W-1:0] col);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_row      <= row;
        i_col      <= col;
        do @(posedge i_clk); while (o_in_stall);
        awaited_results.push_back(predict_table_op(kind, row, col));
        items_sent++;
    endtask

    // Operations on an empty table: every one misses and nothing is stored.
    task automatic test_empty_table();
        send_op(KIND_LOOKUP, 16'h0000, 16'h0000);
        send_op(KIND_REMOVE, 16'hFFFF, 16'hFFFF);
        send_op(KIND_SPARE, 16'h1234, 16'hFEDC);
    endtask

    // Extreme and alternating coordinates, repeated inserts and the spare code.
    task automatic test_extreme_pairs();
        send_op(KIND_INSERT, 16'h0000, 16'h0000);
        send_op(KIND_INSERT, 16'hFFFF, 16'hFFFF);
        send_op(KIND_INSERT, 16'h0000, 16'hFFFF);
        send_op(KIND_INSERT, 16'hFFFF, 16'h0000);
        send_op(KIND_INSERT, 16'hAAAA, 16'h5555);
        send_op(KIND_INSERT, 16'h5555, 16'hAAAA);
        send_op(KIND_INSERT, 16'h0000, 16'h0000);
        send_op(KIND_LOOKUP, 16'hFFFF, 16'hFFFF);
        send_op(KIND_SPARE, 16'h0000, 16'hFFFF);
        send_op(KIND_SPARE, 16'hAAAA, 16'hAAAA);
        send_op(KIND_LOOKUP, 16'h5555, 16'h5555);
    endtask

    // Removal at the front, the back, of an absent pair and in the middle, then a re-insert.
    task automatic test_removal_order();
        send_op(KIND_REMOVE, 16'h0000, 16'h0000);
        send_op(KIND_LOOKUP, 16'h5555, 16'hAAAA);
        send_op(KIND_REMOVE, 16'h5555, 16'hAAAA);
        send_op(KIND_REMOVE, 16'h0000, 16'h0000);
        send_op(KIND_REMOVE, 16'hFFFF, 16'h0000);
        send_op(KIND_LOOKUP, 16'hAAAA, 16'h5555);
        send_op(KIND_INSERT, 16'h0000, 16'h0000);
        send_op(KIND_LOOKUP, 16'h0000, 16'h0000);
    endtask

    // Random operations on a table kept fairly small; most pairs are stored or pooled ones.
    task automatic test_random_mix(input int n_items);
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        int                 roll;
        int                 idx;
        for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(99);
            if (roll < 30)      kind = KIND_LOOKUP;
            else if (roll < 62) kind = KIND_INSERT;
            else if (roll < 92) kind = KIND_REMOVE;
            else                kind = KIND_SPARE;
            if (kind == KIND_INSERT && shadow_count > 40) kind = KIND_REMOVE;
            roll = $urandom_range(99);
            if (roll < 50 && shadow_count > 0) begin
                idx = $urandom_range(shadow_count - 1);
                row = shadow_rows[idx];
                col = shadow_cols[idx];
            end else if (roll < 85) begin
                row = pool_coord($urandom_range(7));
                col = pool_coord($urandom_range(7));
            end else begin
                row = COORD_W'($urandom_range(16'hFFFF));
                col = COORD_W'($urandom_range(16'hFFFF));
            end
            send_op(kind, row, col);
        end
    endtask

    // Fills the table to capacity, then checks refused inserts and the last index.
    task automatic test_full_table();
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        // The fill runs with no gaps between items and no stalls on the result side.
        steady = 1'b1;
        while (shadow_count < TABLE_DEPTH) begin
            draw_fresh_pair(row, col);
            send_op(KIND_INSERT, row, col);
        end
        steady = 1'b0;
        draw_fresh_pair(row, col);
        send_op(KIND_INSERT, row, col);
        send_op(KIND_INSERT, shadow_rows[TABLE_DEPTH-1], shadow_cols[TABLE_DEPTH-1]);
        send_op(KIND_LOOKUP, shadow_rows[0], shadow_cols[0]);
        send_op(KIND_SPARE, shadow_rows[TABLE_DEPTH-1], shadow_cols[TABLE_DEPTH-1]);
        send_op(KIND_REMOVE, shadow_rows[0], shadow_cols[0]);
        draw_fresh_pair(row, col);
        send_op(KIND_INSERT, row, col);
        draw_fresh_pair(row, col);
        send_op(KIND_INSERT, row, col);
        draw_fresh_pair(row, col);
        send_op(KIND_LOOKUP, row, col);
    endtask

    // Empties the full table in random order, with lookups and absent removals between.
    task automatic test_drain();
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        int                 idx;
        int                 roll;
        while (shadow_count > 0) begin
            idx  = $urandom_range(shadow_count - 1);
            roll = $urandom_range(99);
            if (roll < 80) begin
                send_op(KIND_REMOVE, shadow_rows[idx], shadow_cols[idx]);
            end else if (roll < 90) begin
                send_op(KIND_LOOKUP, shadow_rows[idx], shadow_cols[idx]);
            end else begin
                draw_fresh_pair(row, col);
                send_op(KIND_REMOVE, row, col);
            end
        end
    endtask

    // Stops the stimulus, waits for outstanding results and gives the verdict.
    task automatic finish_run();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d items and checked %0d results; %0d found a stored pair,",
                 items_sent, results_seen, hits_seen);
        $display("%0d removals moved later entries; the table reached %0d of %0d entries",
                 shifted_removes, peak_count, TABLE_DEPTH);
        $display("and refused %0d inserts while full.", refused_inserts);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    endtask

    // The result side stalls at random, except during the steady stretch.
    always @(negedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 26);
    end

    // Each accepted result is compared with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("result arrived with no item outstanding");
            end else begin
                want = awaited_results.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch($sformatf("hit %0b, predicted %0b", o_hit, want.hit));
                if (o_position !== want.position)
                    report_mismatch($sformatf("position %0d, predicted %0d",
                                              o_position, want.position));
                if (o_count !== want.count)
                    report_mismatch($sformatf("count %0d, predicted %0d", o_count, want.count));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0b, predicted %0b",
                                              o_status, want.status));
            end
        end
    end

    // Watchdog: too long without any item or result moving ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles with no progress", quiet_cycles);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_extreme_pairs();
        test_removal_order();
        test_random_mix(420);
        test_full_table();
        test_drain();
        test_random_mix(150);
        finish_run();
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/cpst_pkg.sv
rtl/cpst_store.sv
rtl/cpst_seq.sv
rtl/coordinate_pair_set_table.sv
verif/tb.sv
